### sv/palette_selector_skip_off_core_macros.svh
// Assertion macros for the palette selector core.
`ifndef PALETTE_SELECTOR_SKIP_OFF_CORE_MACROS_SVH
`define PALETTE_SELECTOR_SKIP_OFF_CORE_MACROS_SVH

// Check that cons holds in the cycle of ante.
`define PSSO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define PSSO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/psso_pkg.sv
// Types, command codes and default palette for the palette selector core.
package psso_pkg;

   localparam int PTR_W       = 6;
   localparam int CMD_W       = 3;
   localparam int ENTRY_W     = 32;
   localparam int TABLE_DEPTH = 50;

   // Entry layout from the lowest bit up: red, green, blue, white.
   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CMD_W-1:0]   cmd_type;

   localparam cmd_type CMD_NEXT    = 3'd0;
   localparam cmd_type CMD_PREV    = 3'd1;
   localparam cmd_type CMD_SET     = 3'd2;
   localparam cmd_type CMD_WRITE   = 3'd3;
   localparam cmd_type CMD_RESTORE = 3'd4;
   localparam cmd_type CMD_READ    = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam entry_type DEFAULT_TABLE [TABLE_DEPTH] = '{
      32'h000000FF, 32'h0000FF00, 32'h00FF0000, 32'h0000FFFF, 32'h00FF00FF,
      32'h00FFFF00, 32'hFF000000, 32'h00CBC0FF, 32'h00C1B6FF, 32'h00B469FF,
      32'h009314FF, 32'h0000A5FF, 32'h00008CFF, 32'h000045FF, 32'h00507FFF,
      32'h00800080, 32'h00E22B8A, 32'h00D30094, 32'h00D355BA, 32'h00DDA0DD,
      32'h008B0000, 32'h00CD0000, 32'h00FF901E, 32'h00FACE87, 32'h00FFBF00,
      32'h00008000, 32'h00228B22, 32'h007FFF00, 32'h0032CD32, 32'h0090EE90,
      32'h0000D7FF, 32'h00CDFAFF, 32'h00E0FFFF, 32'h002A2AA5, 32'h0013458B,
      32'h001E69D2, 32'h0060A4F4, 32'h00808080, 32'h00C0C0C0, 32'h00A9A9A9,
      32'h00D3D3D3, 32'h320000FF, 32'h3200FF00, 32'h32FF0000, 32'h64008080,
      32'h64808000, 32'h64800080, 32'hC8646464, 32'hFF969696, 32'h00000000
   };

endpackage

### sv/palette_selector_skip_off_core.sv
// Palette selector: writable RGBW palette with a current-entry pointer and skip-off walk.
//
// Input channel req_*: one beat is one command (req_tuser) with an entry index
// and RGBW data (req_tdata). Result channel rsp_*: one beat per command with the
// pointer after the command and the RGBW of the current entry, or of the entry
// read; rsp_tuser flags a read outside the palette with 0.
// A command is taken only while the sequencer is idle. For set, write, restore,
// read and unused codes it steps through exec, fetch, check and done states.
// Next and previous walk the palette through one shared step-and-compare unit,
// one entry per cycle, stepping over off entries until it finds a lit one or
// comes back to the pointer. The block returns to idle when the result is
// loaded into the output register and takes the next command from idle, so it
// never accepts a command before the last one's result is loaded.
// Reset clears the pointer, the handshakes and the per-entry written flags; an
// entry whose flag is clear reads as its default color, so reset and restore
// need no pass over the palette memory.
// A stalled receiver holds the result in the output register; a finished command
// waits there for the register to free before the block returns to idle.
module palette_selector_skip_off_core #(
   parameter int ENTRY_COUNT = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // entry_index, red_in, green_in, blue_in, white_in
   input  logic [2:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pointer_now, red_out, green_out, blue_out, white_out
   output logic [0:0]  rsp_tuser    // read_valid
);

   `include "palette_selector_skip_off_core_macros.svh"

   localparam int IDX_W = $clog2(ENTRY_COUNT);
   localparam psso_pkg::ptr_type LAST_PTR = psso_pkg::PTR_W'(ENTRY_COUNT - 1);
   localparam logic [7:0] COUNT_IDX = 8'(ENTRY_COUNT);

   psso_pkg::state_type state_ff, state_in;
   psso_pkg::cmd_type   cmd_ff, cmd_in;
   logic [7:0]          idx_ff, idx_in;
   psso_pkg::entry_type wr_data_ff, wr_data_in;
   psso_pkg::ptr_type   ptr_ff, ptr_in;
   psso_pkg::ptr_type   addr_ff, addr_in;
   logic                blank_ff, blank_in;
   psso_pkg::ptr_type   res_ptr_ff, res_ptr_in;
   psso_pkg::entry_type res_entry_ff, res_entry_in;
   logic                res_valid_ff, res_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [39:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;
   logic [ENTRY_COUNT-1:0] flag_ff, flag_in;

   psso_pkg::entry_type mem [ENTRY_COUNT];
   psso_pkg::entry_type rd_data_ff;
   logic                hit_ff;
   psso_pkg::entry_type dflt_ff;

   logic                idx_ok;
   logic                walk;
   logic                backward;
   psso_pkg::ptr_type   step_src;
   psso_pkg::ptr_type   step_out;
   psso_pkg::ptr_type   rd_addr;
   psso_pkg::entry_type entry_now;
   logic                keep_walking;
   logic                mem_wr;
   logic                out_free;

   assign idx_ok    = idx_ff < COUNT_IDX;
   assign walk      = (cmd_ff == psso_pkg::CMD_NEXT) || (cmd_ff == psso_pkg::CMD_PREV);
   assign backward  = cmd_ff == psso_pkg::CMD_PREV;
   assign entry_now = hit_ff ? rd_data_ff : dflt_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign mem_wr    = (state_ff == psso_pkg::ST_EXEC) && (cmd_ff == psso_pkg::CMD_WRITE) && idx_ok;

   // shared step unit: one wrapped move of the walk address
   assign step_src = (state_ff == psso_pkg::ST_EXEC) ? ptr_ff : addr_ff;
   always_comb begin
      if (backward) begin
         step_out = (step_src == '0) ? LAST_PTR : step_src - psso_pkg::PTR_W'(1);
      end else begin
         step_out = (step_src == LAST_PTR) ? '0 : step_src + psso_pkg::PTR_W'(1);
      end
   end

   assign keep_walking = walk && (addr_ff != ptr_ff) && (entry_now == '0);
   assign rd_addr      = (state_ff == psso_pkg::ST_CHECK) ? step_out : addr_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      wr_data_in   = wr_data_ff;
      ptr_in       = ptr_ff;
      addr_in      = addr_ff;
      blank_in     = blank_ff;
      res_ptr_in   = res_ptr_ff;
      res_entry_in = res_entry_ff;
      res_valid_in = res_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      flag_in      = flag_ff;

      unique case (state_ff)
         psso_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               idx_in     = req_tdata[7:0];
               wr_data_in = req_tdata[39:8];
               state_in   = psso_pkg::ST_EXEC;
            end
         end
         psso_pkg::ST_EXEC: begin
            blank_in = 1'b0;
            addr_in  = ptr_ff;
            unique case (cmd_ff) inside
               psso_pkg::CMD_NEXT, psso_pkg::CMD_PREV: begin
                  addr_in = step_out;
               end
               psso_pkg::CMD_SET: begin
                  if (idx_ok) begin
                     ptr_in  = idx_ff[psso_pkg::PTR_W-1:0];
                     addr_in = idx_ff[psso_pkg::PTR_W-1:0];
                  end
               end
               psso_pkg::CMD_WRITE: begin
                  if (idx_ok) begin
                     flag_in[idx_ff[IDX_W-1:0]] = 1'b1;
                  end
               end
               psso_pkg::CMD_RESTORE: begin
                  flag_in = '0;
                  ptr_in  = '0;
                  addr_in = '0;
               end
               psso_pkg::CMD_READ: begin
                  if (idx_ok) begin
                     addr_in = idx_ff[psso_pkg::PTR_W-1:0];
                  end else begin
                     blank_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            state_in = psso_pkg::ST_FETCH;
         end
         psso_pkg::ST_FETCH: begin
            state_in = psso_pkg::ST_CHECK;
         end
         psso_pkg::ST_CHECK: begin
            if (keep_walking) begin
               addr_in = step_out;
            end else begin
               if (walk) begin
                  ptr_in = addr_ff;
               end
               res_ptr_in   = walk ? addr_ff : ptr_ff;
               res_entry_in = blank_ff ? '0 : entry_now;
               res_valid_in = !blank_ff;
               state_in     = psso_pkg::ST_DONE;
            end
         end
         psso_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, res_entry_ff, res_ptr_ff};
               rsp_user_in  = res_valid_ff;
               state_in     = psso_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psso_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psso_pkg::ST_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      wr_data_ff   <= wr_data_in;
      addr_ff      <= addr_in;
      blank_ff     <= blank_in;
      res_ptr_ff   <= res_ptr_in;
      res_entry_ff <= res_entry_in;
      res_valid_ff <= res_valid_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // palette memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[idx_ff[IDX_W-1:0]] <= wr_data_ff;
      end
      rd_data_ff <= mem[rd_addr[IDX_W-1:0]];
      hit_ff     <= flag_ff[rd_addr[IDX_W-1:0]];
      dflt_ff    <= psso_pkg::DEFAULT_TABLE[rd_addr];
   end

   assign req_tready = state_ff == psso_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `PSSO_ASSERT_NEXT(a_accept_exec, req_tvalid && req_tready, state_ff == psso_pkg::ST_EXEC, "accepted command did not start execution")
   `PSSO_ASSERT_NOW(a_ptr_range, state_ff == psso_pkg::ST_IDLE, ptr_ff <= LAST_PTR, "pointer outside palette")
   `PSSO_ASSERT_NOW(a_walk_range, state_ff == psso_pkg::ST_CHECK, addr_ff <= LAST_PTR, "walk address outside palette")
   `PSSO_ASSERT_NEXT(a_rsp_load, (state_ff == psso_pkg::ST_DONE) && out_free, rsp_tvalid && req_tready, "result not loaded when output was free")

endmodule

### dv/palette_check_pkg.sv
`timescale 1ns / 1ps
// Default colors, expected-result type and scoreboard for the palette selector testbench.
package palette_check_pkg;

   import psso_pkg::*;

   localparam int ENTRIES = 50;

   localparam cmd_type CMD_SPARE_A = 3'd6;
   localparam cmd_type CMD_SPARE_B = 3'd7;

   // Red, green, blue, white per entry.
   localparam bit [7:0] DEFAULT_RGBW [ENTRIES][4] = '{
      '{255, 0, 0, 0}, '{0, 255, 0, 0}, '{0, 0, 255, 0}, '{255, 255, 0, 0},
      '{255, 0, 255, 0}, '{0, 255, 255, 0}, '{0, 0, 0, 255},
      '{255, 192, 203, 0}, '{255, 182, 193, 0}, '{255, 105, 180, 0}, '{255, 20, 147, 0},
      '{255, 165, 0, 0}, '{255, 140, 0, 0}, '{255, 69, 0, 0}, '{255, 127, 80, 0},
      '{128, 0, 128, 0}, '{138, 43, 226, 0}, '{148, 0, 211, 0}, '{186, 85, 211, 0},
      '{221, 160, 221, 0},
      '{0, 0, 139, 0}, '{0, 0, 205, 0}, '{30, 144, 255, 0}, '{135, 206, 250, 0},
      '{0, 191, 255, 0},
      '{0, 128, 0, 0}, '{34, 139, 34, 0}, '{0, 255, 127, 0}, '{50, 205, 50, 0},
      '{144, 238, 144, 0},
      '{255, 215, 0, 0}, '{255, 250, 205, 0}, '{255, 255, 224, 0},
      '{165, 42, 42, 0}, '{139, 69, 19, 0}, '{210, 105, 30, 0}, '{244, 164, 96, 0},
      '{128, 128, 128, 0}, '{192, 192, 192, 0}, '{169, 169, 169, 0}, '{211, 211, 211, 0},
      '{255, 0, 0, 50}, '{0, 255, 0, 50}, '{0, 0, 255, 50}, '{128, 128, 0, 100},
      '{0, 128, 128, 100}, '{128, 0, 128, 100}, '{100, 100, 100, 200},
      '{150, 150, 150, 255}, '{0, 0, 0, 0}
   };

   typedef struct {
      bit [5:0] ptr;
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit [7:0] white;
      bit       shown_ok;
   } palette_result_type;

   class palette_scoreboard;
      bit [7:0]           colors [ENTRIES][4];
      int                 cursor;
      palette_result_type awaited [$];
      int                 n_errors;
      int                 n_checked;
      int                 n_commands;
      int                 n_walks;
      int                 n_circles;
      int                 n_writes;
      int                 n_bad_reads;

      function new();
         restore_palette();
      endfunction

      function void restore_palette();
         colors = DEFAULT_RGBW;
         cursor = 0;
      endfunction

      function bit entry_off(int i);
         return colors[i][0] == 0 && colors[i][1] == 0 &&
                colors[i][2] == 0 && colors[i][3] == 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_command(cmd_type cmd, bit [7:0] idx, bit [31:0] rgbw);
         int                 start;
         int                 shown;
         bit                 ok;
         palette_result_type r;
         start = cursor;
         ok    = 1'b1;
         n_commands++;
         case (cmd)
            CMD_NEXT, CMD_PREV: begin
               n_walks++;
               do begin
                  if (cmd == CMD_NEXT) cursor = (cursor + 1 >= ENTRIES) ? 0 : cursor + 1;
                  else cursor = (cursor == 0) ? ENTRIES - 1 : cursor - 1;
                  if (cursor == start) begin
                     n_circles++;
                     break;
                  end
               end while (entry_off(cursor));
            end
            CMD_SET: begin
               if (idx < ENTRIES) cursor = idx;
            end
            CMD_WRITE: begin
               if (idx < ENTRIES) begin
                  n_writes++;
                  for (int k = 0; k < 4; k++) colors[idx][k] = rgbw[8*k +: 8];
               end
            end
            CMD_RESTORE: restore_palette();
            CMD_READ: begin
               if (idx >= ENTRIES) begin
                  ok = 1'b0;
                  n_bad_reads++;
               end
            end
            default: ;
         endcase
         shown = (cmd == CMD_READ && ok) ? int'(idx) : cursor;
         r.ptr      = cursor[5:0];
         r.red      = ok ? colors[shown][0] : 8'd0;
         r.green    = ok ? colors[shown][1] : 8'd0;
         r.blue     = ok ? colors[shown][2] : 8'd0;
         r.white    = ok ? colors[shown][3] : 8'd0;
         r.shown_ok = ok;
         awaited.push_back(r);
      endfunction

      function void compare(string field, int expected_v, int actual_v);
         if (expected_v != actual_v) begin
            n_errors++;
            if (n_errors <= 40)
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, field, expected_v, actual_v);
         end
      endfunction

      function void check_result(bit [39:0] d, bit shown_ok);
         palette_result_type e;
         if (awaited.size() == 0) begin
            n_errors++;
            if (n_errors <= 40)
               $display("%0t: result beat with nothing expected, expected none, actual %h",
                        $time, d);
            return;
         end
         e = awaited.pop_front();
         n_checked++;
         compare("pointer_now", e.ptr, d[5:0]);
         compare("red_out", e.red, d[13:6]);
         compare("green_out", e.green, d[21:14]);
         compare("blue_out", e.blue, d[29:22]);
         compare("white_out", e.white, d[37:30]);
         compare("read_valid", e.shown_ok, shown_ok);
      endfunction
   endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench: drives command beats into the palette selector and checks result beats.
module tb_top;

   import psso_pkg::*;
   import palette_check_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 500;

   typedef enum {RX_OPEN, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        hold_rsp   = 1'b0;

   palette_scoreboard tracker;
   int                burst_left = 0;
   int                sent       = 0;
   int                cycles     = 0;
   int                rx_left    = 0;
   rx_mode_type       rx_mode    = RX_OPEN;

   palette_selector_skip_off_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata, rsp_tuser[0]);
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 200);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
         RX_OPEN:     rsp_tready <= !hold_rsp;
         RX_MOSTLY:   rsp_tready <= !hold_rsp && ($urandom_range(0, 9) < 7);
         RX_PERIODIC: rsp_tready <= !hold_rsp && (rx_left % 4 == 0);
         default:     rsp_tready <= !hold_rsp && ($urandom_range(0, 3) == 0);
      endcase
   end

   // hold the result side off so the block backs up into its input
   initial begin
      wait (sent >= HOLD_AFTER);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic issue(cmd_type cmd, bit [7:0] idx, bit [31:0] rgbw);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rgbw, idx};
      do @(posedge clock); while (!req_tready);
      tracker.note_command(cmd, idx, rgbw);
      burst_left = burst_left - 1;
      sent       = sent + 1;
   endtask

   function automatic bit [7:0] rand_index();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 8'($urandom_range(0, ENTRIES - 1));
      if (pick < 75) return 8'd0;
      if (pick < 80) return 8'(ENTRIES - 1);
      return 8'($urandom_range(ENTRIES, 255));
   endfunction

   function automatic bit [31:0] rand_color();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return '0;
      if (pick == 3) return '1;
      return $urandom();
   endfunction

   function automatic cmd_type rand_cmd();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return CMD_NEXT;
      if (pick < 50) return CMD_PREV;
      if (pick < 60) return CMD_SET;
      if (pick < 78) return CMD_WRITE;
      if (pick < 90) return CMD_READ;
      if (pick < 93) return CMD_RESTORE;
      if (pick < 97) return CMD_SPARE_A;
      return CMD_SPARE_B;
   endfunction

   task automatic mixed_run();
      repeat ($urandom_range(10, 30)) issue(rand_cmd(), rand_index(), rand_color());
   endtask

   // blank most or all entries, then walk across the gaps
   task automatic sparse_run();
      int keep_pct;
      int pick;
      keep_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
      for (int i = 0; i < ENTRIES; i++)
         if ($urandom_range(0, 99) >= keep_pct) issue(CMD_WRITE, 8'(i), '0);
      repeat ($urandom_range(6, 20)) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) issue(CMD_NEXT, rand_index(), rand_color());
         else if (pick < 8) issue(CMD_PREV, rand_index(), rand_color());
         else if (pick == 8) issue(CMD_READ, rand_index(), rand_color());
         else issue(CMD_SET, rand_index(), rand_color());
      end
      if ($urandom_range(0, 1) == 1) issue(CMD_RESTORE, rand_index(), rand_color());
   endtask

   initial begin
      int target;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_READ, 8'd0, '0);
      issue(CMD_PREV, 8'd0, '0);
      issue(CMD_NEXT, 8'd255, '1);
      issue(CMD_SET, 8'(ENTRIES - 1), '0);
      issue(CMD_NEXT, 8'd0, '0);
      issue(CMD_SET, 8'(ENTRIES), '0);
      issue(CMD_SET, 8'd255, '0);
      issue(CMD_WRITE, 8'd255, '1);
      issue(CMD_WRITE, 8'd0, '1);
      issue(CMD_READ, 8'd0, '0);
      issue(CMD_WRITE, 8'd1, '0);
      issue(CMD_NEXT, 8'd0, '0);
      issue(CMD_PREV, 8'd0, '0);
      issue(CMD_READ, 8'(ENTRIES - 1), '0);
      issue(CMD_READ, 8'(ENTRIES), '0);
      issue(CMD_READ, 8'd255, '1);
      issue(CMD_SPARE_A, 8'd3, '1);
      issue(CMD_SPARE_B, 8'd4, '1);
      issue(CMD_WRITE, 8'(ENTRIES - 1), 32'h0102_0304);
      issue(CMD_SET, 8'(ENTRIES - 2), '0);
      issue(CMD_NEXT, 8'd0, '0);
      issue(CMD_RESTORE, 8'd255, '1);
      issue(CMD_READ, 8'(ENTRIES - 1), '0);

      target = sent + RANDOM_ITEMS;
      while (sent < target) begin
         if ($urandom_range(0, 3) == 0) sparse_run();
         else mixed_run();
      end
      req_tvalid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands: %0d walks (%0d back at their start), %0d writes,",
               tracker.n_commands, tracker.n_walks, tracker.n_circles, tracker.n_writes);
      $display("%0d reads off the end; checked %0d result beats, %0d mismatches.",
               tracker.n_bad_reads, tracker.n_checked, tracker.n_errors);
      if (tracker.n_errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
